@@ sv/rlp_transaction_validator_core_defines.svh @@
// assertion macros for the transaction validator
`ifndef RLP_TRANSACTION_VALIDATOR_CORE_DEFINES_SVH
`define RLP_TRANSACTION_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RLPV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rlpv check failed");

// next-cycle implication, checked out of reset
`define RLPV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rlpv check failed");

`endif

@@ sv/rlpv_pkg.sv @@
// shared types, codes and helpers for the transaction validator
`default_nettype none

package rlpv_pkg;

    localparam int unsigned ACC_W = 32;
    localparam int unsigned LENGTH_WIDTH_DEF = 31;

    typedef logic [3:0] t_field;
    typedef logic [2:0] t_verdict;

    localparam t_field FLD_OUTER     = 4'd0;
    localparam t_field FLD_NONCE     = 4'd1;
    localparam t_field FLD_GAS_PRICE = 4'd2;
    localparam t_field FLD_GAS_LIMIT = 4'd3;
    localparam t_field FLD_ADDRESS   = 4'd4;
    localparam t_field FLD_VALUE     = 4'd5;
    localparam t_field FLD_DATA      = 4'd6;
    localparam t_field FLD_V         = 4'd7;
    localparam t_field FLD_R         = 4'd8;
    localparam t_field FLD_S         = 4'd9;
    localparam t_field FLD_DONE      = 4'd10;

    localparam t_verdict VERD_PENDING    = 3'd0;
    localparam t_verdict VERD_VALID      = 3'd1;
    localparam t_verdict VERD_BAD_PREFIX = 3'd2;
    localparam t_verdict VERD_BAD_LENGTH = 3'd3;
    localparam t_verdict VERD_BOUND      = 3'd4;

    localparam logic [7:0] PFX_STRING      = 8'h80;
    localparam logic [7:0] PFX_STRING_LONG = 8'hb8;
    localparam logic [7:0] PFX_LIST        = 8'hc0;
    localparam logic [7:0] PFX_LIST_LONG   = 8'hf8;
    localparam logic [5:0] PFX_LOW_MAX     = 6'h3b;
    localparam logic [5:0] PFX_LONG_BASE   = 6'h37;

    localparam logic [ACC_W-1:0] MAX_NUM_LEN = 32'd32;
    localparam logic [ACC_W-1:0] ADDR_LEN    = 32'd20;
    localparam logic [ACC_W-1:0] V_LEN       = 32'd1;

    typedef struct packed {
        t_field     field_index;
        logic [2:0] hdr_left;
        logic       in_payload;
        t_verdict   err;
    } t_ctl;

    function automatic logic len_ok(input t_field f, input logic [ACC_W-1:0] len);
        logic ok;
        case (f)
            FLD_NONCE, FLD_GAS_PRICE, FLD_GAS_LIMIT, FLD_VALUE: ok = (len <= MAX_NUM_LEN);
            FLD_ADDRESS: ok = (len == ADDR_LEN);
            FLD_V:       ok = (len == V_LEN);
            FLD_R, FLD_S: ok = (len == '0);
            default:     ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ sv/rlpv_if.sv @@
// handshake channels for input bytes and tagged result items
`default_nettype none

interface rlpv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rlpv_out_if;
    logic                valid;
    logic                ready;
    logic [7:0]          byte_out;
    rlpv_pkg::t_field    field_tag;
    logic                is_header;
    logic                end_of_tx;
    rlpv_pkg::t_verdict  verdict;

    modport source (output valid, output byte_out, output field_tag, output is_header,
                    output end_of_tx, output verdict, input ready);
    modport sink (input valid, input byte_out, input field_tag, input is_header,
                  input end_of_tx, input verdict, output ready);
endinterface

`default_nettype wire

@@ sv/rlpv_parse.sv @@
// per-byte parse step: next parser state and result tags for one item
`default_nettype none

module rlpv_parse #(
    parameter int unsigned LENGTH_WIDTH = rlpv_pkg::LENGTH_WIDTH_DEF
) (
    input  rlpv_pkg::t_ctl                i_ctl,
    input  logic [rlpv_pkg::ACC_W-1:0]    i_item,
    input  logic [LENGTH_WIDTH-1:0]       i_outer,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    output rlpv_pkg::t_ctl                o_ctl,
    output logic [rlpv_pkg::ACC_W-1:0]    o_item,
    output logic [LENGTH_WIDTH-1:0]       o_outer,
    output rlpv_pkg::t_field              o_tag,
    output logic                          o_hdr,
    output rlpv_pkg::t_verdict            o_verdict
);

    rlpv_pkg::t_ctl                 ctl;
    logic [rlpv_pkg::ACC_W-1:0]     item;
    logic [LENGTH_WIDTH-1:0]        outer;
    logic                           do_hd;
    logic                           do_done;
    logic [rlpv_pkg::ACC_W-1:0]     hd_len;
    logic [5:0]                     low;
    logic [5:0]                     hdr_cnt;
    logic                           is_short;

    always_comb begin
        ctl      = i_ctl;
        item     = i_item;
        outer    = i_outer;
        do_hd    = 1'b0;
        do_done  = 1'b0;
        hd_len   = '0;
        o_hdr    = 1'b0;
        low      = i_byte[5:0];
        hdr_cnt  = low - rlpv_pkg::PFX_LONG_BASE;
        is_short = (i_byte < rlpv_pkg::PFX_STRING_LONG)
                || (i_byte >= rlpv_pkg::PFX_LIST && i_byte < rlpv_pkg::PFX_LIST_LONG);
        o_tag    = (i_ctl.field_index < rlpv_pkg::FLD_DONE) ? i_ctl.field_index
                                                            : rlpv_pkg::FLD_OUTER;

        if (i_ctl.err == rlpv_pkg::VERD_PENDING) begin
            if (i_ctl.field_index >= rlpv_pkg::FLD_DONE) begin
                ctl.err = rlpv_pkg::VERD_BOUND;
            end else if (i_ctl.field_index != rlpv_pkg::FLD_OUTER && i_outer == '0) begin
                ctl.err = rlpv_pkg::VERD_BOUND;
            end else begin
                if (i_ctl.field_index != rlpv_pkg::FLD_OUTER) begin
                    outer = i_outer - 1'b1;
                end
                if (i_ctl.hdr_left != '0) begin
                    o_hdr        = 1'b1;
                    item         = {i_item[rlpv_pkg::ACC_W-9:0], i_byte};
                    ctl.hdr_left = i_ctl.hdr_left - 1'b1;
                    if (ctl.hdr_left == '0) begin
                        do_hd  = 1'b1;
                        hd_len = item;
                    end
                end else if (i_ctl.in_payload) begin
                    item = i_item - 1'b1;
                    if (item == '0) begin
                        do_done = 1'b1;
                    end
                end else if (i_byte < rlpv_pkg::PFX_STRING) begin
                    // single byte item
                    if (i_ctl.field_index == rlpv_pkg::FLD_OUTER) begin
                        outer   = '0;
                        do_done = 1'b1;
                    end else if (!rlpv_pkg::len_ok(i_ctl.field_index, rlpv_pkg::V_LEN)) begin
                        ctl.err = rlpv_pkg::VERD_BAD_LENGTH;
                    end else begin
                        do_done = 1'b1;
                    end
                end else begin
                    o_hdr = 1'b1;
                    if (is_short) begin
                        do_hd  = 1'b1;
                        hd_len = {{(rlpv_pkg::ACC_W-6){1'b0}}, low};
                    end else if (low > rlpv_pkg::PFX_LOW_MAX) begin
                        ctl.err = rlpv_pkg::VERD_BAD_PREFIX;
                    end else begin
                        ctl.hdr_left = hdr_cnt[2:0];
                        item         = '0;
                    end
                end
            end
        end

        // header complete: range, outer fit, empty item
        if (do_hd) begin
            if ((|hd_len[rlpv_pkg::ACC_W-1:LENGTH_WIDTH])
                    || !rlpv_pkg::len_ok(ctl.field_index, hd_len)) begin
                ctl.err = rlpv_pkg::VERD_BAD_LENGTH;
            end else if (ctl.field_index == rlpv_pkg::FLD_OUTER) begin
                outer           = hd_len[LENGTH_WIDTH-1:0];
                ctl.field_index = rlpv_pkg::FLD_NONCE;
                ctl.in_payload  = 1'b0;
            end else if (hd_len[LENGTH_WIDTH-1:0] > outer) begin
                ctl.err = rlpv_pkg::VERD_BOUND;
            end else if (hd_len == '0) begin
                do_done = 1'b1;
            end else begin
                item           = hd_len;
                ctl.in_payload = 1'b1;
            end
        end

        if (do_done) begin
            ctl.field_index = ctl.field_index + 1'b1;
            ctl.in_payload  = 1'b0;
            item            = '0;
        end

        o_verdict = rlpv_pkg::VERD_PENDING;
        if (i_last) begin
            if (ctl.err != rlpv_pkg::VERD_PENDING) begin
                o_verdict = ctl.err;
            end else if (ctl.field_index == rlpv_pkg::FLD_DONE && outer == '0) begin
                o_verdict = rlpv_pkg::VERD_VALID;
            end else begin
                o_verdict = rlpv_pkg::VERD_BOUND;
            end
        end

        // back to the start for the next transaction
        if (i_last) begin
            o_ctl   = '0;
            o_item  = '0;
            o_outer = '0;
        end else begin
            o_ctl   = ctl;
            o_item  = item;
            o_outer = outer;
        end
    end

endmodule

`default_nettype wire

@@ sv/rlp_transaction_validator_core.sv @@
// an accepted byte is held in the input register, then shows as a result item in the result register
// throughput: one byte per cycle unless the output stalls; parse state updates as a byte leaves the input register
// ready to the input drops only while both the input and result registers hold items
// reset clears the parse state and both valid flags; the block then expects an outer header
// after the result for the last byte the state returns to its reset values
`default_nettype none
`include "rlp_transaction_validator_core_defines.svh"

module rlp_transaction_validator_core #(
    parameter int unsigned LENGTH_WIDTH = rlpv_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlpv_in_if.sink     i_in,
    rlpv_out_if.source  o_out
);

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic                           r_in_last;

    logic                           r_out_valid;
    logic [7:0]                     r_out_byte;
    rlpv_pkg::t_field               r_out_tag;
    logic                           r_out_hdr;
    logic                           r_out_last;
    rlpv_pkg::t_verdict             r_out_verdict;

    rlpv_pkg::t_ctl                 r_ctl;
    logic [rlpv_pkg::ACC_W-1:0]     r_item;
    logic [LENGTH_WIDTH-1:0]        r_outer;

    rlpv_pkg::t_ctl                 n_ctl;
    logic [rlpv_pkg::ACC_W-1:0]     n_item;
    logic [LENGTH_WIDTH-1:0]        n_outer;
    rlpv_pkg::t_field               n_tag;
    logic                           n_hdr;
    rlpv_pkg::t_verdict             n_verdict;

    logic                           out_free;
    logic                           stage_go;
    logic                           in_acc;

    assign out_free = !r_out_valid || o_out.ready;
    assign stage_go = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_acc = i_in.valid && i_in.ready;

    rlpv_parse #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parse (
        .i_ctl     (r_ctl),
        .i_item    (r_item),
        .i_outer   (r_outer),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_ctl     (n_ctl),
        .o_item    (n_item),
        .o_outer   (n_outer),
        .o_tag     (n_tag),
        .o_hdr     (n_hdr),
        .o_verdict (n_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= '0;
            r_item      <= '0;
            r_outer     <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (stage_go) begin
                r_in_valid <= 1'b0;
            end
            if (stage_go) begin
                r_out_valid <= 1'b1;
                r_ctl       <= n_ctl;
                r_item      <= n_item;
                r_outer     <= n_outer;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (stage_go) begin
            r_out_byte    <= r_in_byte;
            r_out_tag     <= n_tag;
            r_out_hdr     <= n_hdr;
            r_out_last    <= r_in_last;
            r_out_verdict <= n_verdict;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.byte_out  = r_out_byte;
    assign o_out.field_tag = r_out_tag;
    assign o_out.is_header = r_out_hdr;
    assign o_out.end_of_tx = r_out_last;
    assign o_out.verdict   = r_out_verdict;

    // state returns to start after the last byte of a transaction
    `RLPV_ASSERT_NEXT(a_reset_after_last, i_clk, i_rst_n, stage_go && r_in_last,
        r_ctl == '0 && r_outer == '0)
    // verdict only on the final byte
    `RLPV_ASSERT_IMP(a_verdict_on_last, i_clk, i_rst_n, r_out_valid && !r_out_last,
        r_out_verdict == rlpv_pkg::VERD_PENDING)
    // first error is kept until the transaction ends
    `RLPV_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n,
        r_ctl.err != rlpv_pkg::VERD_PENDING && !(stage_go && r_in_last),
        $stable(r_ctl.err))
    // long form has at most four length bytes
    `RLPV_ASSERT_IMP(a_hdr_left_range, i_clk, i_rst_n, r_ctl.hdr_left != '0,
        r_ctl.hdr_left <= 3'd4)

endmodule

`default_nettype wire
